FILE: design/scalar_kalman_filter_top_macros.svh
// Assertion macros for the scalar Kalman filter.
// Used by the top level; depends on nothing.
`ifndef SCALAR_KALMAN_FILTER_TOP_MACROS_SVH
`define SCALAR_KALMAN_FILTER_TOP_MACROS_SVH
// implication checked on every edge outside reset
`define SKF_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define SKF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: design/skf_pkg.sv
// Types, codes and fixed-point helpers for the scalar Kalman filter.
// No dependencies.
package skf_pkg;
	localparam int unsigned QFRAC = 16;

	// register indexes
	localparam logic [1:0] REG_STATE_GAIN   = 2'd0;
	localparam logic [1:0] REG_OBSERVE_GAIN = 2'd1;
	localparam logic [1:0] REG_PROC_NOISE   = 2'd2;
	localparam logic [1:0] REG_MEAS_NOISE   = 2'd3;

	localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

	// multiplier operand selects
	typedef enum logic [3:0] {
		OP_C, OP_A, OP_X, OP_P, OP_MEAS, OP_T0, OP_T1, OP_PP, OP_XP, OP_K, OP_ZERO
	} opsel_t;

	// destination of a step result
	typedef enum logic [3:0] {
		DST_NONE, DST_T0, DST_T1, DST_PP, DST_XP, DST_K, DST_X, DST_P
	} dst_t;

	typedef enum logic [1:0] {
		ALU_MUL, ALU_ADD, ALU_SUB
	} alu_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_P_DIV1, ST_P_WAIT1, ST_P_CC, ST_P_DIV2, ST_P_WAIT2,
		ST_XP, ST_AP, ST_APA, ST_PPQ, ST_CP, ST_CPC, ST_DEN, ST_PC, ST_KDIV, ST_KWAIT,
		ST_CXP, ST_INNOV, ST_KI, ST_XNEW, ST_KC, ST_KCP, ST_PNEW,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic   load;
		logic   alu_go;
		alu_t   alu;
		opsel_t op_a;
		opsel_t op_b;
		dst_t   dst;
		logic   div_start;
		opsel_t div_n;
		opsel_t div_d;
		dst_t   div_dst;
		logic   div_capture;
		logic   set_primed;
	} skf_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic primed;
		logic div_busy;
	} skf_sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'(SAT_MAX)) return SAT_MAX;
		if (v < 66'(SAT_MIN)) return SAT_MIN;
		return v[31:0];
	endfunction
endpackage

FILE: design/skf_if.sv
// Valid/ready channel interface for the filter ports.
// Parameterised by payload width; no dependencies.
interface skf_if #(parameter int W = 16) (input logic clk);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/skf_div.sv
// Iterative signed Q16.16 divider: quotient = n*2^16/d, truncated, saturated.
// Depends on skf_pkg; one quotient bit per cycle.
module skf_div
	import skf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	// 33 bits so that an unsigned 32-bit noise level enters unchanged
	input  logic signed [32:0] num,
	input  logic signed [31:0] den,
	output logic               busy,
	output logic signed [31:0] quot
);
	logic [47:0] dvd_q;
	logic [47:0] quo_q;
	logic [31:0] dvs_q;
	logic [32:0] rem_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic        zero_q;
	logic        nneg_q;
	logic [32:0] trial;
	logic [32:0] rem_sh;
	logic signed [49:0] sq;

	assign rem_sh = {rem_q[31:0], dvd_q[47]};
	assign trial  = rem_sh - {1'b0, dvs_q};

	// restoring division on magnitudes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy  <= (den != 0);
			cnt_q <= 6'd48;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= {(num[32] ? 32'(-num) : 32'(num)), 16'd0};
			dvs_q  <= den[31] ? 32'(-den) : 32'(den);
			rem_q  <= '0;
			quo_q  <= '0;
			neg_q  <= num[32] ^ den[31];
			zero_q <= (den == 0);
			nneg_q <= num[32];
		end else if (busy) begin
			dvd_q <= {dvd_q[46:0], 1'b0};
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	// sign and saturation
	always_comb begin
		sq = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
		if (zero_q) quot = nneg_q ? SAT_MIN : SAT_MAX;
		else        quot = sat32(66'(sq));
	end
endmodule

FILE: design/skf_datapath.sv
// Datapath: configuration, state, scratch registers, shared multiplier/adder
// and the divider. Depends on skf_pkg and skf_div.
module skf_datapath
	import skf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  skf_cmd_t           cmd,
	output skf_sts_t           sts,
	input  logic signed [15:0] sample,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [31:0]        cfg_data,
	output logic [31:0]        cfg_rdata,
	output logic signed [31:0] estimate
);
	logic signed [23:0] a_q, c_q;
	logic [31:0] q_q, r_q;
	logic signed [31:0] x_q, p_q, meas_q;
	logic        primed_q;
	logic signed [31:0] t0_q, t1_q, pp_q, xp_q, k_q;
	logic signed [31:0] opa, opb, dn, dd, res, dq;
	logic signed [32:0] div_num;
	logic signed [63:0] prod;
	logic        dbusy;

	function automatic logic signed [31:0] pick(input opsel_t s,
		input logic signed [23:0] a, input logic signed [23:0] c,
		input logic signed [31:0] x, input logic signed [31:0] p,
		input logic signed [31:0] m, input logic signed [31:0] t0,
		input logic signed [31:0] t1, input logic signed [31:0] pp,
		input logic signed [31:0] xp, input logic signed [31:0] k);
		unique case (s)
			OP_C:    return 32'(c);
			OP_A:    return 32'(a);
			OP_X:    return x;
			OP_P:    return p;
			OP_MEAS: return m;
			OP_T0:   return t0;
			OP_T1:   return t1;
			OP_PP:   return pp;
			OP_XP:   return xp;
			OP_K:    return k;
			default: return 32'sd0;
		endcase
	endfunction

	// operand selection; Q and R are unsigned and enter the adder separately
	always_comb begin
		opa = pick(cmd.op_a, a_q, c_q, x_q, p_q, meas_q, t0_q, t1_q, pp_q, xp_q, k_q);
		opb = pick(cmd.op_b, a_q, c_q, x_q, p_q, meas_q, t0_q, t1_q, pp_q, xp_q, k_q);
		dn  = pick(cmd.div_n, a_q, c_q, x_q, p_q, meas_q, t0_q, t1_q, pp_q, xp_q, k_q);
		dd  = pick(cmd.div_d, a_q, c_q, x_q, p_q, meas_q, t0_q, t1_q, pp_q, xp_q, k_q);
	end

	// one multiply, add or subtract per step, truncated toward zero, saturated
	always_comb begin
		prod = opa * opb;
		unique case (cmd.alu)
			ALU_MUL: res = sat32(66'(prod / 65536));
			ALU_ADD: begin
				if (cmd.op_b == OP_ZERO && cmd.dst == DST_PP)
					res = sat32(66'(opa) + 66'({1'b0, q_q}));
				else if (cmd.op_b == OP_ZERO)
					res = sat32(66'(opa) + 66'({1'b0, r_q}));
				else
					res = sat32(66'(opa) + 66'(opb));
			end
			ALU_SUB: res = sat32(66'(opa) - 66'(opb));
			default: res = '0;
		endcase
	end

	// divider numerator: R stays unsigned, everything else is sign extended
	assign div_num = (cmd.div_n == OP_ZERO) ? $signed({1'b0, r_q}) : 33'(dn);

	skf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (dd),
		.busy   (dbusy),
		.quot   (dq)
	);

	// configuration registers, state and primed flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q      <= 24'sd65536;
			c_q      <= 24'sd65536;
			q_q      <= 32'd65536;
			r_q      <= 32'd65536;
			x_q      <= '0;
			p_q      <= '0;
			primed_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_STATE_GAIN:   a_q <= cfg_data[23:0];
					REG_OBSERVE_GAIN: c_q <= cfg_data[23:0];
					REG_PROC_NOISE:   q_q <= cfg_data;
					REG_MEAS_NOISE:   r_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.set_primed) primed_q <= 1'b1;
			if (cmd.alu_go && cmd.dst == DST_X) x_q <= res;
			if (cmd.alu_go && cmd.dst == DST_P) p_q <= res;
			if (cmd.div_capture && cmd.div_dst == DST_X) x_q <= dq;
			if (cmd.div_capture && cmd.div_dst == DST_P) p_q <= dq;
		end
	end

	// scratch registers
	always_ff @(posedge clk) begin
		if (cmd.load) meas_q <= {sample, 16'd0};
		if (cmd.alu_go) begin
			unique case (cmd.dst)
				DST_T0:  t0_q <= res;
				DST_T1:  t1_q <= res;
				DST_PP:  pp_q <= res;
				DST_XP:  xp_q <= res;
				DST_K:   k_q  <= res;
				default: ;
			endcase
		end
		if (cmd.div_capture && cmd.div_dst == DST_K) k_q <= dq;
	end

	always_comb begin
		unique case (cfg_idx)
			REG_STATE_GAIN:   cfg_rdata = 32'(a_q);
			REG_OBSERVE_GAIN: cfg_rdata = 32'(c_q);
			REG_PROC_NOISE:   cfg_rdata = q_q;
			default:          cfg_rdata = r_q;
		endcase
	end

	assign estimate       = x_q;
	assign sts.primed     = primed_q;
	assign sts.div_busy   = dbusy;
endmodule

FILE: design/skf_ctrl.sv
// Sequencer for the filter steps; drives the datapath through skf_cmd_t.
// Depends on skf_pkg.
module skf_ctrl
	import skf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  skf_sts_t sts,
	output skf_cmd_t cmd
);
	state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (in_valid) state_d = sts.primed ? ST_XP : ST_P_DIV1;
			ST_P_DIV1:  state_d = ST_P_WAIT1;
			ST_P_WAIT1: if (!sts.div_busy) state_d = ST_P_CC;
			ST_P_CC:    state_d = ST_P_DIV2;
			ST_P_DIV2:  state_d = ST_P_WAIT2;
			ST_P_WAIT2: if (!sts.div_busy) state_d = ST_OUT;
			ST_XP:      state_d = ST_AP;
			ST_AP:      state_d = ST_APA;
			ST_APA:     state_d = ST_PPQ;
			ST_PPQ:     state_d = ST_CP;
			ST_CP:      state_d = ST_CPC;
			ST_CPC:     state_d = ST_DEN;
			ST_DEN:     state_d = ST_PC;
			ST_PC:      state_d = ST_KDIV;
			ST_KDIV:    state_d = ST_KWAIT;
			ST_KWAIT:   if (!sts.div_busy) state_d = ST_CXP;
			ST_CXP:     state_d = ST_INNOV;
			ST_INNOV:   state_d = ST_KI;
			ST_KI:      state_d = ST_XNEW;
			ST_XNEW:    state_d = ST_KC;
			ST_KC:      state_d = ST_KCP;
			ST_KCP:     state_d = ST_PNEW;
			ST_PNEW:    state_d = ST_OUT;
			ST_OUT:     if (out_ready) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// command outputs
	always_comb begin
		cmd = '{load: 1'b0, alu_go: 1'b0, alu: ALU_MUL, op_a: OP_ZERO, op_b: OP_ZERO,
			dst: DST_NONE, div_start: 1'b0, div_n: OP_ZERO, div_d: OP_ZERO,
			div_dst: DST_NONE, div_capture: 1'b0, set_primed: 1'b0};
		in_ready  = (state_q == ST_IDLE);
		out_valid = (state_q == ST_OUT);
		unique case (state_q)
			ST_IDLE: cmd.load = in_valid;
			ST_P_DIV1: begin
				cmd.div_start = 1'b1; cmd.div_n = OP_MEAS; cmd.div_d = OP_C;
			end
			ST_P_WAIT1: begin
				cmd.div_n = OP_MEAS; cmd.div_d = OP_C;
				cmd.div_dst = DST_X; cmd.div_capture = !sts.div_busy;
			end
			ST_P_CC: begin
				cmd.alu_go = 1'b1; cmd.op_a = OP_C; cmd.op_b = OP_C; cmd.dst = DST_T0;
			end
			// numerator OP_ZERO selects R in the datapath
			ST_P_DIV2: begin
				cmd.div_start = 1'b1; cmd.div_n = OP_ZERO; cmd.div_d = OP_T0;
			end
			ST_P_WAIT2: begin
				cmd.div_dst = DST_P; cmd.div_capture = !sts.div_busy;
				cmd.set_primed = !sts.div_busy;
			end
			ST_XP: begin
				cmd.alu_go = 1'b1; cmd.op_a = OP_A; cmd.op_b = OP_X; cmd.dst = DST_XP;
			end
			ST_AP: begin
				cmd.alu_go = 1'b1; cmd.op_a = OP_A; cmd.op_b = OP_P; cmd.dst = DST_T0;
			end
			ST_APA: begin
				cmd.alu_go = 1'b1; cmd.op_a = OP_T0; cmd.op_b = OP_A; cmd.dst = DST_T0;
			end
			ST_PPQ: begin
				cmd.alu_go = 1'b1; cmd.alu = ALU_ADD; cmd.op_a = OP_T0; cmd.dst = DST_PP;
			end
			ST_CP: begin
				cmd.alu_go = 1'b1; cmd.op_a = OP_C; cmd.op_b = OP_PP; cmd.dst = DST_T0;
			end
			ST_CPC: begin
				cmd.alu_go = 1'b1; cmd.op_a = OP_T0; cmd.op_b = OP_C; cmd.dst = DST_T0;
			end
			ST_DEN: begin
				cmd.alu_go = 1'b1; cmd.alu = ALU_ADD; cmd.op_a = OP_T0; cmd.dst = DST_T1;
			end
			ST_PC: begin
				cmd.alu_go = 1'b1; cmd.op_a = OP_PP; cmd.op_b = OP_C; cmd.dst = DST_T0;
			end
			ST_KDIV: begin
				cmd.div_start = 1'b1; cmd.div_n = OP_T0; cmd.div_d = OP_T1;
			end
			ST_KWAIT: begin
				cmd.div_dst = DST_K; cmd.div_capture = !sts.div_busy;
			end
			ST_CXP: begin
				cmd.alu_go = 1'b1; cmd.op_a = OP_C; cmd.op_b = OP_XP; cmd.dst = DST_T0;
			end
			ST_INNOV: begin
				cmd.alu_go = 1'b1; cmd.alu = ALU_SUB; cmd.op_a = OP_MEAS; cmd.op_b = OP_T0;
				cmd.dst = DST_T0;
			end
			ST_KI: begin
				cmd.alu_go = 1'b1; cmd.op_a = OP_K; cmd.op_b = OP_T0; cmd.dst = DST_T0;
			end
			ST_XNEW: begin
				cmd.alu_go = 1'b1; cmd.alu = ALU_ADD; cmd.op_a = OP_XP; cmd.op_b = OP_T0;
				cmd.dst = DST_X;
			end
			ST_KC: begin
				cmd.alu_go = 1'b1; cmd.op_a = OP_K; cmd.op_b = OP_C; cmd.dst = DST_T0;
			end
			ST_KCP: begin
				cmd.alu_go = 1'b1; cmd.op_a = OP_T0; cmd.op_b = OP_PP; cmd.dst = DST_T0;
			end
			ST_PNEW: begin
				cmd.alu_go = 1'b1; cmd.alu = ALU_SUB; cmd.op_a = OP_PP; cmd.op_b = OP_T0;
				cmd.dst = DST_P;
			end
			default: ;
		endcase
	end
endmodule

FILE: design/scalar_kalman_filter_top.sv
// Scalar Kalman filter: one signed sample word in, one Q16.16 estimate word out.
// Once primed, a sample runs 15 multiply/add steps on one shared 32x32 multiplier and one
// bit-serial gain division; the priming sample runs C*C and two divisions, which the
// divider skips when C is zero. The word is held until taken and the next sample is
// taken in the cycle after, so no new sample is taken before the last word is taken.
// Depends on skf_pkg, skf_if, skf_ctrl, skf_datapath and the macros header.
`include "scalar_kalman_filter_top_macros.svh"
module scalar_kalman_filter_top
	import skf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	skf_if.sink         in_ch,
	skf_if.source       out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	skf_cmd_t cmd;
	skf_sts_t sts;
	logic     cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	skf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	skf_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.sample    (in_ch.data),
		.cfg_we    (cfg_we && paddr[1:0] == 2'b00),
		.cfg_idx   (paddr[3:2]),
		.cfg_data  (pwdata),
		.cfg_rdata (prdata),
		.estimate  (out_ch.data)
	);

	// a result is never offered while an input is taken
	`SKF_ASSERT_IMPL(a_no_overlap, in_ch.ready, !out_ch.valid, "ready and valid together")
	// the first result follows a primed filter
	`SKF_ASSERT_IMPL(a_primed_out, out_ch.valid, sts.primed, "result before priming")
	// an accepted item starts work next cycle
	`SKF_ASSERT_NEXT(a_start, in_ch.valid && in_ch.ready, !in_ch.ready, "item not started")
endmodule

FILE: sim/tb_scalar_kalman_filter_top.sv
// Self-checking testbench for scalar_kalman_filter_top: sample words in, estimate words out,
// each checked against a fixed-point filter predictor. Depends on skf_pkg, skf_if and the RTL.
module tb_scalar_kalman_filter_top;
	import skf_pkg::*;

	localparam longint Q1 = 65536;
	localparam longint QMAX = 64'sd2147483647;
	localparam longint QMIN = -64'sd2147483648;

	typedef struct {
		logic signed [23:0] a;
		logic signed [23:0] c;
		logic [31:0]        q;
		logic [31:0]        r;
	} filt_cfg_t;

	typedef struct {
		int                 phase;
		logic signed [15:0] sample;
		bit                 has_est;
		logic [31:0]        est;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	skf_if #(16) sample_ch (clk);
	skf_if #(32) est_ch (clk);

	scalar_kalman_filter_top dut (
		.clk(clk), .arst_n(arst_n), .in_ch(sample_ch.sink), .out_ch(est_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state and live register copy
	filt_cfg_t   cfg;
	longint      x_est, p_var;
	bit          is_primed;
	logic [31:0] est_q[$];
	int          errs, n_sent, n_checked, n_cfg;
	bit          quiet;
	bit          did_long_hold;

	filt_cfg_t   dir_cfg[5];
	dir_row_t    dir_tab[$];

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#40_000_000;
		$display("tb_scalar_kalman_filter_top: FAIL");
		$finish;
	end

	function automatic longint sat(longint v);
		if (v > QMAX) return QMAX;
		if (v < QMIN) return QMIN;
		return v;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return sat((a * b) / Q1);
	endfunction

	function automatic longint qdiv(longint n, longint d);
		if (d == 0) return (n < 0) ? QMIN : QMAX;
		return sat((n * Q1) / d);
	endfunction

	// one filter step on the predictor state, returns the new estimate word
	function automatic logic [31:0] filter_step(logic signed [15:0] s);
		longint meas, a, c, q, r, xp, pp, den, k, innov;
		meas = longint'(s) * Q1;
		a = longint'(cfg.a);
		c = longint'(cfg.c);
		q = longint'(cfg.q);
		r = longint'(cfg.r);
		if (!is_primed) begin
			x_est = qdiv(meas, c);
			p_var = qdiv(r, qmul(c, c));
			is_primed = 1;
		end else begin
			xp = qmul(a, x_est);
			pp = sat(qmul(qmul(a, p_var), a) + q);
			den = sat(qmul(qmul(c, pp), c) + r);
			k = qdiv(qmul(pp, c), den);
			innov = sat(meas - qmul(c, xp));
			x_est = sat(xp + qmul(k, innov));
			p_var = sat(pp - qmul(qmul(k, c), pp));
		end
		return x_est[31:0];
	endfunction

	task automatic apb_write(logic [1:0] idx, logic [31:0] val);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		@(posedge clk);
	endtask

	// write all four registers; only called with nothing in flight
	task automatic load_cfg(filt_cfg_t nc);
		apb_write(REG_STATE_GAIN, {{8{nc.a[23]}}, nc.a});
		apb_write(REG_OBSERVE_GAIN, {{8{nc.c[23]}}, nc.c});
		apb_write(REG_PROC_NOISE, nc.q);
		apb_write(REG_MEAS_NOISE, nc.r);
		cfg = nc;
		n_cfg++;
	endtask

	// wait for every expected word
	task automatic drain();
		sample_ch.valid <= 0;
		while (est_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// offer one word; entered at the edge of the previous acceptance, left at that of its own
	task automatic send_sample(logic signed [15:0] s, bit has_est, logic [31:0] est);
		int gap;
		logic [31:0] pred;
		gap = 0;
		if (!quiet) begin
			case ($urandom_range(0, 99)) inside
				[0:74]: gap = 0;
				[75:94]: gap = $urandom_range(1, 3);
				default: gap = $urandom_range(10, 60);
			endcase
		end
		if (gap > 0) begin
			sample_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1;
		sample_ch.data <= s;
		do @(posedge clk); while (!sample_ch.ready);
		pred = filter_step(s);
		if (has_est && pred !== est) begin
			$error("predictor disagrees on table row: estimate expected %h got %h", est, pred);
			errs++;
		end
		est_q.push_back(has_est ? est : pred);
		n_sent++;
	endtask

	function automatic filt_cfg_t rand_cfg();
		filt_cfg_t nc;
		case ($urandom_range(0, 3))
			0: nc.a = 24'sh7FFFFF;
			1: nc.a = 24'($urandom);
			default: nc.a = 24'(65536 + $urandom_range(0, 16384) - 8192);
		endcase
		case ($urandom_range(0, 4))
			0: nc.c = 24'sh800000;
			1: nc.c = 24'($urandom);
			2: nc.c = '0;
			default: nc.c = 24'(65536 + $urandom_range(0, 32768) - 16384);
		endcase
		nc.q = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 18);
		nc.r = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 22);
		if ($urandom_range(0, 7) == 0) nc.q = 32'hFFFF_FFFF;
		if ($urandom_range(0, 7) == 0) nc.r = '0;
		return nc;
	endfunction

	// result side: check each accepted word, then choose next ready
	initial begin
		int hold;
		logic [31:0] want;
		hold = 0;
		est_ch.ready = 0;
		forever begin
			@(posedge clk);
			if (arst_n && est_ch.valid && est_ch.ready) begin
				if (est_q.size() == 0) begin
					$error("estimate word %h with none expected", est_ch.data);
					errs++;
				end else begin
					want = est_q.pop_front();
					n_checked++;
					if (est_ch.data !== want) begin
						$error("estimate expected %h got %h", want, est_ch.data);
						errs++;
					end
				end
			end
			// one long hold-off so the block backs up into the sample side
			if (!did_long_hold && n_checked == 300) begin
				did_long_hold = 1;
				hold = 600;
			end
			if (hold > 0) begin
				hold--;
				est_ch.ready <= 0;
			end else if (!quiet && $urandom_range(0, 99) < 8) begin
				hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
				est_ch.ready <= 0;
			end else begin
				est_ch.ready <= 1;
			end
		end
	end

	// stimulus
	initial begin
		int ph;
		int walk;
		logic signed [15:0] s;
		errs = 0; n_sent = 0; n_checked = 0; n_cfg = 0;
		quiet = 0; did_long_hold = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		sample_ch.valid = 0; sample_ch.data = 0;
		cfg = '{a: 24'sd65536, c: 24'sd65536, q: 32'd65536, r: 32'd65536};
		x_est = 0; p_var = 0; is_primed = 0;

		dir_cfg[0] = '{a: 24'sd65536, c: 24'sd0, q: 32'd65536, r: 32'd65536};
		dir_cfg[1] = '{a: 24'sd65536, c: 24'sd0, q: 32'd0, r: 32'd0};
		dir_cfg[2] = '{a: 24'sh7FFFFF, c: 24'sh800000, q: 32'hFFFF_FFFF, r: 32'hFFFF_FFFF};
		dir_cfg[3] = '{a: 24'sh800000, c: 24'sh7FFFFF, q: 32'd0, r: 32'd0};
		dir_cfg[4] = '{a: 24'sd65536, c: 24'sd65536, q: 32'd65536, r: 32'd65536};

		// priming with C = 0 divides by zero: negative sample goes to the low extreme
		dir_tab = '{
			'{0, -16'sd32768, 1, 32'h8000_0000},
			'{0, 16'sd1000, 0, 0},
			'{0, -16'sd1, 0, 0},
			// zero gain denominator
			'{1, 16'sd5, 0, 0},
			'{1, -16'sd7, 0, 0},
			'{1, 16'sd0, 0, 0},
			// extreme gains and noise
			'{2, 16'sd32767, 0, 0},
			'{2, -16'sd32768, 0, 0},
			'{2, 16'sd0, 0, 0},
			'{2, 16'sd1, 0, 0},
			'{3, -16'sd32768, 0, 0},
			'{3, 16'sd32767, 0, 0},
			'{3, -16'sd1, 0, 0},
			// unity settings, a steady then jumping signal
			'{4, 16'sd100, 0, 0},
			'{4, 16'sd101, 0, 0},
			'{4, 16'sd99, 0, 0},
			'{4, 16'sd100, 0, 0},
			'{4, 16'sd0, 0, 0},
			'{4, 16'sd32767, 0, 0},
			'{4, -16'sd32768, 0, 0},
			'{4, -16'sd1, 0, 0}
		};

		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed table
		ph = -1;
		foreach (dir_tab[i]) begin
			if (dir_tab[i].phase != ph) begin
				drain();
				ph = dir_tab[i].phase;
				load_cfg(dir_cfg[ph]);
			end
			send_sample(dir_tab[i].sample, dir_tab[i].has_est, dir_tab[i].est);
		end

		// random phases: mostly slowly moving signals, some noise and extremes
		for (int p = 0; p < 10; p++) begin
			drain();
			load_cfg(rand_cfg());
			quiet = (p % 4 == 3);
			walk = $urandom_range(0, 2000) - 1000;
			for (int n = 0; n < 190; n++) begin
				case ($urandom_range(0, 19))
					0: s = 16'sh7FFF;
					1: s = 16'sh8000;
					2, 3: s = 16'($urandom);
					default: begin
						walk = walk + $urandom_range(0, 20) - 10;
						if (walk > 32767) walk = 32767;
						if (walk < -32768) walk = -32768;
						s = 16'(walk);
					end
				endcase
				send_sample(s, 0, 0);
			end
		end

		drain();
		repeat (100) @(posedge clk);
		$display("Covered %0d samples over %0d register settings, %0d estimates checked.",
			n_sent, n_cfg, n_checked);
		$display("Included priming and gain division by zero, extreme gains and a long hold-off.");
		if (errs == 0 && est_q.size() == 0)
			$display("tb_scalar_kalman_filter_top: PASS");
		else
			$display("tb_scalar_kalman_filter_top: FAIL");
		$finish;
	end
endmodule
